### rtl/core/temp_humidity_compensation_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the temperature and humidity compensation core
// Concurrent checks are compiled in simulation and left empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEMP_HUMIDITY_COMPENSATION_CORE_MACROS_SVH
`define TEMP_HUMIDITY_COMPENSATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on i_clk and disabled while reset is low.
`define THC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("thc assertion failed");
// Next-cycle implication, clocked on i_clk and disabled while reset is low.
`define THC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("thc assertion failed");
`else
`define THC_ASSERT_IMP(lbl, ante, cons)
`define THC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// Shared widths, register codes, calibration bundle and helpers of the core.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int C_RAW_T_W    = 20;
    localparam int C_RAW_H_W    = 16;
    localparam int C_WORD_W     = 32;
    localparam int C_HUM_W      = 17;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 16;
    localparam int C_STAGES     = 15;

    localparam logic [31:0] C_X_OFS    = 32'd76800;
    localparam logic [31:0] C_HUM_RND  = 32'd16384;
    localparam logic [31:0] C_R_OFS    = 32'd32768;
    localparam logic [31:0] C_Q_OFS    = 32'd2097152;
    localparam logic [31:0] C_Q_RND    = 32'd8192;
    localparam logic [31:0] C_HUM_MAX  = 32'd419430400;
    localparam logic [31:0] C_CENT_RND = 32'd128;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_TEMP_CAL_ONE      = 3'd0,
        CFG_TEMP_CAL_TWO      = 3'd1,
        CFG_TEMP_CAL_THREE    = 3'd2,
        CFG_HUM_CAL_ONE_THREE = 3'd3,
        CFG_HUM_CAL_TWO       = 3'd4,
        CFG_HUM_CAL_FOUR      = 3'd5,
        CFG_HUM_CAL_FIVE      = 3'd6,
        CFG_HUM_CAL_SIX       = 3'd7
    } t_cfg_idx;

    // Calibration words, already extended to the 32-bit arithmetic width.
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] h4;
        logic [31:0] h5;
        logic [31:0] h6;
    } t_cal;

    // Arithmetic right shift of a 32-bit two's complement word.
    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

endpackage

### rtl/core/thc_sample_if.sv
// ----------------------------------------------------------------------------
// thc_sample_if
// Raw sample channel: one temperature and one humidity conversion per transfer.
// ----------------------------------------------------------------------------
interface thc_sample_if;
    logic                           valid;
    logic                           ready;
    logic [thc_pkg::C_RAW_T_W-1:0]  raw_temperature;
    logic [thc_pkg::C_RAW_H_W-1:0]  raw_humidity;

    modport source (output valid, output raw_temperature, output raw_humidity, input ready);
    modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

### rtl/core/thc_result_if.sv
// ----------------------------------------------------------------------------
// thc_result_if
// Result channel: compensated temperature and humidity per transfer.
// ----------------------------------------------------------------------------
interface thc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [thc_pkg::C_WORD_W-1:0] fine_temperature;
    logic signed [thc_pkg::C_WORD_W-1:0] temperature_centi;
    logic [thc_pkg::C_HUM_W-1:0]        humidity_q10;

    modport source (output valid, output fine_temperature, output temperature_centi,
                    output humidity_q10, input ready);
    modport sink   (input valid, input fine_temperature, input temperature_centi,
                    input humidity_q10, output ready);
endinterface

### rtl/core/thc_cfg_if.sv
// ----------------------------------------------------------------------------
// thc_cfg_if
// Configuration write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface thc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [thc_pkg::C_CFG_IDX_W-1:0]   index;
    logic [thc_pkg::C_CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/thc_pipe.sv
// ----------------------------------------------------------------------------
// thc_pipe
// Fifteen-stage compensation datapath with per-stage valid bits and stalls.
// ----------------------------------------------------------------------------
`include "temp_humidity_compensation_core_macros.svh"

module thc_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  thc_pkg::t_cal                  i_cal,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [thc_pkg::C_RAW_T_W-1:0]  i_raw_temperature,
    input  logic [thc_pkg::C_RAW_H_W-1:0]  i_raw_humidity,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_fine_temperature,
    output logic [31:0]                    o_temperature_centi,
    output logic [thc_pkg::C_HUM_W-1:0]    o_humidity_q10
);

    localparam int L = thc_pkg::C_STAGES;

    logic [L-1:0] r_v;
    logic [L-1:0] en;

    // A stage may load when some stage at or after it is empty, or the output drains.
    for (genvar k = 0; k < L; k++) begin : g_en
        assign en[k] = i_ready || !(&r_v[L-1:k]);
    end

    assign o_ready = en[0];
    assign o_valid = r_v[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < L; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage registers.
    logic [31:0] r_u, r_d;
    logic [31:0] r_m1, r_dd;
    logic [31:0] r_a, r_e;
    logic [31:0] r_x, r_c5;
    logic [31:0] r_mh5, r_q0, r_r0;
    logic [31:0] r_qa, r_r;
    logic [31:0] r_qm, r_q1, r_q2m, r_q2;
    logic [31:0] r_ss, r_t;
    logic [thc_pkg::C_HUM_W-1:0] r_hum;
    logic [31:0] r_hbase [0:5];
    logic [31:0] r_fine  [3:14];
    logic [31:0] r_cent  [5:14];
    logic [31:0] r_p     [6:10];
    logic [31:0] r_x2    [11:13];

    logic [31:0] n_hbase;
    logic [31:0] n_diff;
    logic [31:0] n_clamp;

    assign n_hbase = {2'b00, i_raw_humidity, 14'b0} - {i_cal.h4[11:0], 20'b0}
                   + thc_pkg::C_HUM_RND;

    // Final humidity term minus its quadratic correction, then clamped.
    always_comb begin
        n_diff = r_x2[13] - thc_pkg::asr(r_t, 4);
        if (n_diff[31]) begin
            n_clamp = '0;
        end else if (n_diff > thc_pkg::C_HUM_MAX) begin
            n_clamp = thc_pkg::C_HUM_MAX;
        end else begin
            n_clamp = n_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_u        <= {15'b0, i_raw_temperature[19:3]} - {15'b0, i_cal.t1[15:0], 1'b0};
            r_d        <= {16'b0, i_raw_temperature[19:4]} - i_cal.t1;
            r_hbase[0] <= n_hbase;
        end
        if (en[1]) begin
            r_m1 <= r_u * i_cal.t2;
            r_dd <= r_d * r_d;
        end
        if (en[2]) begin
            r_a <= thc_pkg::asr(r_m1, 11);
            r_e <= thc_pkg::asr(r_dd, 12) * i_cal.t3;
        end
        if (en[3]) begin
            r_fine[3] <= r_a + thc_pkg::asr(r_e, 14);
        end
        if (en[4]) begin
            r_x  <= r_fine[3] - thc_pkg::C_X_OFS;
            r_c5 <= {r_fine[3][29:0], 2'b00} + r_fine[3] + thc_pkg::C_CENT_RND;
        end
        if (en[5]) begin
            r_mh5     <= i_cal.h5 * r_x;
            r_q0      <= r_x * i_cal.h6;
            r_r0      <= r_x * i_cal.h3;
            r_cent[5] <= thc_pkg::asr(r_c5, 8);
        end
        if (en[6]) begin
            r_p[6] <= thc_pkg::asr(r_hbase[5] - r_mh5, 15);
            r_qa   <= thc_pkg::asr(r_q0, 10);
            r_r    <= thc_pkg::asr(r_r0, 11) + thc_pkg::C_R_OFS;
        end
        if (en[7]) begin
            r_qm <= r_qa * r_r;
        end
        if (en[8]) begin
            r_q1 <= thc_pkg::asr(r_qm, 10) + thc_pkg::C_Q_OFS;
        end
        if (en[9]) begin
            r_q2m <= r_q1 * i_cal.h2;
        end
        if (en[10]) begin
            r_q2 <= thc_pkg::asr(r_q2m + thc_pkg::C_Q_RND, 14);
        end
        if (en[11]) begin
            r_x2[11] <= r_p[10] * r_q2;
        end
        if (en[12]) begin
            r_ss <= thc_pkg::asr(r_x2[11], 15) * thc_pkg::asr(r_x2[11], 15);
        end
        if (en[13]) begin
            r_t <= thc_pkg::asr(r_ss, 7) * i_cal.h1;
        end
        if (en[14]) begin
            r_hum <= n_clamp[28:12];
        end

        // Values that ride along unchanged with their item.
        for (int k = 1; k <= 5; k++) begin
            if (en[k]) begin
                r_hbase[k] <= r_hbase[k-1];
            end
        end
        for (int k = 4; k <= 14; k++) begin
            if (en[k]) begin
                r_fine[k] <= r_fine[k-1];
            end
        end
        for (int k = 6; k <= 14; k++) begin
            if (en[k]) begin
                r_cent[k] <= r_cent[k-1];
            end
        end
        for (int k = 7; k <= 10; k++) begin
            if (en[k]) begin
                r_p[k] <= r_p[k-1];
            end
        end
        for (int k = 12; k <= 13; k++) begin
            if (en[k]) begin
                r_x2[k] <= r_x2[k-1];
            end
        end
    end

    assign o_fine_temperature  = r_fine[14];
    assign o_temperature_centi = r_cent[14];
    assign o_humidity_q10      = r_hum;

    `THC_ASSERT_IMP(a_hum_range, r_v[L-1], r_hum <= 17'd102400)
    `THC_ASSERT_IMP(a_cent_aligned, r_v[L-1],
        r_cent[14] == thc_pkg::asr(r_fine[14] * 32'd5 + 32'd128, 8))
    `THC_ASSERT_NXT(a_mid_hold, r_v[7] && !en[8], r_v[7] && $stable(r_qm))
    `THC_ASSERT_NXT(a_fine_move, r_v[3] && en[4], r_v[4] && (r_fine[4] == $past(r_fine[3])))

endmodule

### rtl/core/temp_humidity_compensation_core.sv
// ----------------------------------------------------------------------------
// temp_humidity_compensation_core
// Integer temperature and humidity compensation with calibration registers.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the sample channel carries a raw 20-bit temperature and a
// raw 16-bit humidity conversion. Each one yields exactly one transfer on the
// result channel with the fine temperature term, the temperature in 0.01 degC
// and the relative humidity in 1/1024 %RH, clamped to 0..100 %RH.
// The datapath is a 15-stage pipeline, at most one multiply level per stage;
// a new sample can be taken every cycle while the result channel is ready or
// a stage is empty. The multiply chain of the humidity formula sets the depth.
// Calibration words are written on the configuration channel, which is always
// ready; write them only while no sample is in flight.
// Reset clears all calibration registers to zero and empties the pipeline.
// When the receiver stalls, items pack into empty stages behind the output,
// so samples are still taken until every stage is full; nothing is lost.
// ----------------------------------------------------------------------------
module temp_humidity_compensation_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thc_sample_if.sink    i_sample,
    thc_result_if.source  o_result,
    thc_cfg_if.sink       i_cfg
);

    logic [15:0] r_temp_cal_one;
    logic [15:0] r_temp_cal_two;
    logic [15:0] r_temp_cal_three;
    logic [15:0] r_hum_cal_one_three;
    logic [15:0] r_hum_cal_two;
    logic [11:0] r_hum_cal_four;
    logic [11:0] r_hum_cal_five;
    logic [7:0]  r_hum_cal_six;

    thc_pkg::t_cal cal;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal_one      <= '0;
            r_temp_cal_two      <= '0;
            r_temp_cal_three    <= '0;
            r_hum_cal_one_three <= '0;
            r_hum_cal_two       <= '0;
            r_hum_cal_four      <= '0;
            r_hum_cal_five      <= '0;
            r_hum_cal_six       <= '0;
        end else if (i_cfg.valid) begin
            case (thc_pkg::t_cfg_idx'(i_cfg.index))
                thc_pkg::CFG_TEMP_CAL_ONE:      r_temp_cal_one      <= i_cfg.data;
                thc_pkg::CFG_TEMP_CAL_TWO:      r_temp_cal_two      <= i_cfg.data;
                thc_pkg::CFG_TEMP_CAL_THREE:    r_temp_cal_three    <= i_cfg.data;
                thc_pkg::CFG_HUM_CAL_ONE_THREE: r_hum_cal_one_three <= i_cfg.data;
                thc_pkg::CFG_HUM_CAL_TWO:       r_hum_cal_two       <= i_cfg.data;
                thc_pkg::CFG_HUM_CAL_FOUR:      r_hum_cal_four      <= i_cfg.data[11:0];
                thc_pkg::CFG_HUM_CAL_FIVE:      r_hum_cal_five      <= i_cfg.data[11:0];
                thc_pkg::CFG_HUM_CAL_SIX:       r_hum_cal_six       <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Extend every calibration word to the 32-bit arithmetic width.
    always_comb begin
        cal.t1 = {16'b0, r_temp_cal_one};
        cal.t2 = {{16{r_temp_cal_two[15]}}, r_temp_cal_two};
        cal.t3 = {{16{r_temp_cal_three[15]}}, r_temp_cal_three};
        cal.h1 = {24'b0, r_hum_cal_one_three[7:0]};
        cal.h3 = {24'b0, r_hum_cal_one_three[15:8]};
        cal.h2 = {{16{r_hum_cal_two[15]}}, r_hum_cal_two};
        cal.h4 = {{20{r_hum_cal_four[11]}}, r_hum_cal_four};
        cal.h5 = {{20{r_hum_cal_five[11]}}, r_hum_cal_five};
        cal.h6 = {{24{r_hum_cal_six[7]}}, r_hum_cal_six};
    end

    logic [31:0] fine_temperature;
    logic [31:0] temperature_centi;

    thc_pipe u_pipe (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cal               (cal),
        .i_valid             (i_sample.valid),
        .o_ready             (i_sample.ready),
        .i_raw_temperature   (i_sample.raw_temperature),
        .i_raw_humidity      (i_sample.raw_humidity),
        .o_valid             (o_result.valid),
        .i_ready             (o_result.ready),
        .o_fine_temperature  (fine_temperature),
        .o_temperature_centi (temperature_centi),
        .o_humidity_q10      (o_result.humidity_q10)
    );

    assign o_result.fine_temperature  = $signed(fine_temperature);
    assign o_result.temperature_centi = $signed(temperature_centi);

endmodule
